// File: sv/exptok_pkg.sv
`timescale 1ns / 1ps
// exptok_pkg: shared types, character codes and token codes of the expression tokenizer
// no dependencies

package exptok_pkg;

   // width of the number accumulator: saturation point is 2^ACC_W - 1
   localparam int NUMBER_BITS = 32;
   localparam int ACC_W       = (NUMBER_BITS > 32) ? 32 : NUMBER_BITS;
   localparam int NUM_W       = 32;
   localparam int SLOTS       = 6;

   // character classes, also the run class
   localparam logic [1:0] CLS_NONE   = 2'd0;
   localparam logic [1:0] CLS_DIGIT  = 2'd1;
   localparam logic [1:0] CLS_LETTER = 2'd2;
   localparam logic [1:0] CLS_SYMBOL = 2'd3;

   // token kinds
   localparam logic [1:0] KIND_NUMBER = 2'd0;
   localparam logic [1:0] KIND_OPER   = 2'd1;
   localparam logic [1:0] KIND_ARG    = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   // operator codes
   localparam logic [3:0] OP_NONE  = 4'd0;
   localparam logic [3:0] OP_PLUS  = 4'd1;
   localparam logic [3:0] OP_MINUS = 4'd2;
   localparam logic [3:0] OP_MUL   = 4'd3;
   localparam logic [3:0] OP_DIV   = 4'd4;
   localparam logic [3:0] OP_LPAR  = 4'd5;
   localparam logic [3:0] OP_RPAR  = 4'd6;
   localparam logic [3:0] OP_SIN   = 4'd7;
   localparam logic [3:0] OP_COS   = 4'd8;
   localparam logic [3:0] OP_TAN   = 4'd9;
   localparam logic [3:0] OP_LOG   = 4'd10;
   localparam logic [3:0] OP_LN    = 4'd11;
   localparam logic [3:0] OP_EXP   = 4'd12;
   localparam logic [3:0] OP_POW   = 4'd13;

   // symbol characters
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_POW   = 8'h5E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;

   // function names, first letter in the top byte
   localparam logic [23:0] WORD_SIN = "sin";
   localparam logic [23:0] WORD_COS = "cos";
   localparam logic [23:0] WORD_TAN = "tan";
   localparam logic [23:0] WORD_LOG = "log";
   localparam logic [23:0] WORD_EXP = "exp";
   localparam logic [15:0] WORD_LN  = "ln";

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_EN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_EN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_LETTER = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_LETTER = 2'd3;

   localparam logic [7:0] RST_FIRST_LETTER  = 8'd120;
   localparam logic [7:0] RST_SECOND_LETTER = 8'd121;

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       op;
      logic [NUM_W-1:0] num;
      logic             arg;
   } token_type;

   typedef struct packed {
      logic             first_en;
      logic             second_en;
      logic [7:0]       first_letter;
      logic [7:0]       second_letter;
   } cfg_type;

   // tokens given by closing one run
   typedef struct packed {
      logic [1:0]      hit;
      token_type [1:0] tok;
   } close_type;

   // all candidate tokens of one character, in output order
   typedef struct packed {
      logic [SLOTS-1:0]      hit;
      token_type [SLOTS-1:0] tok;
   } slots_type;

endpackage

// File: sv/exptok_if.sv
`timescale 1ns / 1ps
// exptok channel interfaces: character requests, token results, register writes
// depends on exptok_pkg for the register index width

interface exptok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_final;

   modport source (output valid, output char_code, output is_final, input ready);
   modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

interface exptok_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  token_kind;
   logic [3:0]  operator_code;
   logic [31:0] number_value;
   logic        arg_index;
   logic        last_of_run;

   modport source (output valid, output token_kind, output operator_code,
                   output number_value, output arg_index, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input operator_code,
                   input number_value, input arg_index, input last_of_run,
                   output ready);
endinterface

interface exptok_csr_if;
   logic                          valid;
   logic                          ready;
   logic [exptok_pkg::CSR_IDX_W-1:0] index;
   logic [7:0]                    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/exptok_lexer.sv
`timescale 1ns / 1ps
// exptok_lexer: run state registers and per-character token generation
// depends on exptok_pkg

module exptok_lexer import exptok_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [7:0] char_code,
   input  logic       is_final,
   input  cfg_type    cfg,
   output slots_type  slots
);

   logic [1:0]       run_class_ff, run_class_in;
   logic [ACC_W-1:0] accum_ff, accum_in;
   logic [2:0]       letter_count_ff, letter_count_in;
   logic [7:0]       letter_ff [3];
   logic [7:0]       letter_in [3];

   logic [1:0]       cls;
   logic             changed;
   logic [ACC_W-1:0] base_acc, new_acc;
   logic [2:0]       base_cnt, new_cnt;
   logic [ACC_W+3:0] prod;
   logic [3:0]       op_sym;
   close_type        close_prev, close_fin;

   function automatic close_type close_run(input logic [1:0] rc,
                                           input logic [ACC_W-1:0] acc,
                                           input logic [7:0] b0,
                                           input logic [7:0] b1,
                                           input logic [7:0] b2,
                                           input logic [2:0] cnt,
                                           input cfg_type c);
      close_type r;
      r = '0;
      unique case (rc)
         CLS_DIGIT: begin
            r.hit[0]      = 1'b1;
            r.tok[0].kind = KIND_NUMBER;
            r.tok[0].num  = NUM_W'(acc);
         end
         CLS_LETTER: begin
            r.tok[0].kind = KIND_OPER;
            if (cnt == 3'd1) begin
               r.tok[0].kind = KIND_ARG;
               r.tok[1].kind = KIND_ARG;
               r.tok[1].arg  = 1'b1;
               r.hit[0] = c.first_en && (b0 == c.first_letter);
               r.hit[1] = c.second_en && (b0 == c.second_letter);
            end else if (cnt == 3'd2) begin
               r.hit[0]    = ({b0, b1} == WORD_LN);
               r.tok[0].op = OP_LN;
            end else if (cnt == 3'd3) begin
               r.hit[0] = 1'b1;
               priority if ({b0, b1, b2} == WORD_SIN) r.tok[0].op = OP_SIN;
               else if ({b0, b1, b2} == WORD_COS) r.tok[0].op = OP_COS;
               else if ({b0, b1, b2} == WORD_TAN) r.tok[0].op = OP_TAN;
               else if ({b0, b1, b2} == WORD_LOG) r.tok[0].op = OP_LOG;
               else if ({b0, b1, b2} == WORD_EXP) r.tok[0].op = OP_EXP;
               else r.hit[0] = 1'b0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always_comb begin
      if (char_code >= CH_0 && char_code <= CH_9) begin
         cls = CLS_DIGIT;
      end else if ((char_code >= CH_LA && char_code <= CH_LZ) ||
                   (char_code >= CH_UA && char_code <= CH_UZ)) begin
         cls = CLS_LETTER;
      end else begin
         cls = CLS_SYMBOL;
      end

      changed  = (cls != run_class_ff);
      base_acc = changed ? '0 : accum_ff;
      base_cnt = changed ? 3'd0 : letter_count_ff;

      // acc * 10 + digit; any carry into the top bits means saturation
      prod = ({4'd0, base_acc} << 3) + ({4'd0, base_acc} << 1)
             + (ACC_W+4)'(char_code - CH_0);

      new_acc = base_acc;
      new_cnt = base_cnt;
      for (int i = 0; i < 3; i++) begin
         letter_in[i] = letter_ff[i];
      end
      if (cls == CLS_DIGIT) begin
         new_acc = (|prod[ACC_W+3:ACC_W]) ? '1 : prod[ACC_W-1:0];
      end else if (cls == CLS_LETTER) begin
         for (int i = 0; i < 3; i++) begin
            if (base_cnt == 3'(i)) letter_in[i] = char_code;
         end
         if (base_cnt < 3'd4) new_cnt = base_cnt + 3'd1;
      end

      unique case (char_code)
         CH_PLUS:  op_sym = OP_PLUS;
         CH_MINUS: op_sym = OP_MINUS;
         CH_MUL:   op_sym = OP_MUL;
         CH_DIV:   op_sym = OP_DIV;
         CH_LPAR:  op_sym = OP_LPAR;
         CH_RPAR:  op_sym = OP_RPAR;
         CH_POW:   op_sym = OP_POW;
         default:  op_sym = OP_NONE;
      endcase

      close_prev = changed ? close_run(run_class_ff, accum_ff, letter_ff[0],
                                       letter_ff[1], letter_ff[2],
                                       letter_count_ff, cfg)
                           : '0;
      close_fin  = is_final ? close_run(cls, new_acc, letter_in[0], letter_in[1],
                                        letter_in[2], new_cnt, cfg)
                            : '0;

      slots             = '0;
      slots.hit[1:0]    = close_prev.hit;
      slots.tok[1:0]    = close_prev.tok;
      slots.hit[2]      = (cls == CLS_SYMBOL) && (op_sym != OP_NONE);
      slots.tok[2].kind = KIND_OPER;
      slots.tok[2].op   = op_sym;
      slots.hit[4:3]    = close_fin.hit;
      slots.tok[4:3]    = close_fin.tok;
      slots.hit[5]      = is_final;
      slots.tok[5].kind = KIND_END;

      if (is_final) begin
         run_class_in    = CLS_NONE;
         accum_in        = '0;
         letter_count_in = 3'd0;
      end else begin
         run_class_in    = cls;
         accum_in        = new_acc;
         letter_count_in = new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_class_ff    <= CLS_NONE;
         accum_ff        <= '0;
         letter_count_ff <= 3'd0;
      end else if (load) begin
         run_class_ff    <= run_class_in;
         accum_ff        <= accum_in;
         letter_count_ff <= letter_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            letter_ff[i] <= letter_in[i];
         end
      end
   end

   a_count_in_letter_run: assert property (@(posedge clock) disable iff (reset)
      (run_class_ff != CLS_LETTER) |-> (letter_count_ff == 3'd0))
      else $error("letter count open outside a letter run");

   a_accum_in_digit_run: assert property (@(posedge clock) disable iff (reset)
      (run_class_ff != CLS_DIGIT) |-> (accum_ff == '0))
      else $error("number accumulator nonzero outside a digit run");

endmodule

// File: sv/exptok_queue.sv
`timescale 1ns / 1ps
// exptok_queue: holds the tokens of one character and hands them out one per cycle while out_ready is high
// depends on exptok_pkg

module exptok_queue import exptok_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  slots_type slots,
   output logic      load_ok,
   output logic      out_valid,
   input  logic      out_ready,
   output token_type out_tok,
   output logic      out_last
);

   logic [SLOTS-1:0]      hit_ff, hit_in;
   token_type [SLOTS-1:0] tok_ff;
   logic [SLOTS-1:0]      pick;
   logic [SLOTS-1:0]      rest;

   always_comb begin
      pick      = hit_ff & (~hit_ff + SLOTS'(1));
      rest      = hit_ff & ~pick;
      out_valid = |hit_ff;
      out_last  = (rest == '0);
      out_tok   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (pick[i]) out_tok = tok_ff[i];
      end
      load_ok = !out_valid || (out_last && out_ready);

      if (load) begin
         hit_in = slots.hit;
      end else if (out_valid && out_ready) begin
         hit_in = rest;
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) tok_ff <= slots.tok;
   end

   a_at_most_four: assert property (@(posedge clock) disable iff (reset)
      $countones(hit_ff) <= 4)
      else $error("more than four tokens held for one character");

endmodule

// File: sv/expression_tokenizer.sv
`timescale 1ns / 1ps
// expression_tokenizer: top level of the streaming expression lexer
// depends on exptok_pkg, exptok_if, exptok_lexer, exptok_queue
//
// the first token of a request shows on rsp in the cycle after the request is accepted
// one request per cycle while each gives at most one token and rsp is ready; the queue
//   drains one token per cycle while rsp is ready, so a request that gives more (up to
//   four) holds the queue, which takes a new request only as its last token leaves
// reset (synchronous): configuration registers return to defaults, no run open, token queue empty

module expression_tokenizer import exptok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   exptok_req_if.sink   req_port,
   exptok_rsp_if.source rsp_port,
   exptok_csr_if.sink   csr_port
);

   // configuration registers
   logic       first_arg_enable_ff;
   logic       second_arg_enable_ff;
   logic [7:0] first_arg_letter_ff;
   logic [7:0] second_arg_letter_ff;
   cfg_type    cfg;

   logic       req_fire;
   logic       load_ok;
   slots_type  slots;
   token_type  out_tok;
   logic       out_valid;
   logic       out_last;

   // register writes are always taken
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_arg_enable_ff  <= 1'b1;
         second_arg_enable_ff <= 1'b0;
         first_arg_letter_ff  <= RST_FIRST_LETTER;
         second_arg_letter_ff <= RST_SECOND_LETTER;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            REG_FIRST_EN:      first_arg_enable_ff  <= csr_port.data[0];
            REG_SECOND_EN:     second_arg_enable_ff <= csr_port.data[0];
            REG_FIRST_LETTER:  first_arg_letter_ff  <= csr_port.data;
            REG_SECOND_LETTER: second_arg_letter_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   assign cfg = '{first_en:      first_arg_enable_ff,
                  second_en:     second_arg_enable_ff,
                  first_letter:  first_arg_letter_ff,
                  second_letter: second_arg_letter_ff};

   // a request is taken when the queue is empty or its last token leaves now
   assign req_port.ready = load_ok;
   assign req_fire       = req_port.valid && load_ok;

   // run state and token candidates for the incoming character
   exptok_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .char_code (req_port.char_code),
      .is_final  (req_port.is_final),
      .cfg       (cfg),
      .slots     (slots)
   );

   // result register: tokens of the last request, lowest slot first
   exptok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .slots     (slots),
      .load_ok   (load_ok),
      .out_valid (out_valid),
      .out_ready (rsp_port.ready),
      .out_tok   (out_tok),
      .out_last  (out_last)
   );

   assign rsp_port.valid         = out_valid;
   assign rsp_port.token_kind    = out_tok.kind;
   assign rsp_port.operator_code = out_tok.op;
   assign rsp_port.number_value  = out_tok.num;
   assign rsp_port.arg_index     = out_tok.arg;
   assign rsp_port.last_of_run   = out_last;

   // a new request never overtakes tokens still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!rsp_port.valid || (rsp_port.ready && rsp_port.last_of_run)))
      else $error("request accepted while tokens still pending");

   // a token not marked last is always followed by another
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.ready && !rsp_port.last_of_run) |=> rsp_port.valid)
      else $error("token run ended without a last marker");

endmodule

// File: test/exptok_checker.sv
`timescale 1ns / 1ps
// exptok_checker: watches the character, token and register channels of the tokenizer
// and compares every token with its own prediction; depends on exptok_pkg and exptok_if

module exptok_checker import exptok_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   exptok_req_if req_mon,
   exptok_rsp_if rsp_mon,
   exptok_csr_if csr_mon,
   output int    error_count,
   output int    pending_count,
   output int    token_count
);

   typedef struct packed {
      token_type tok;
      logic      last;
   } token_rec;

   localparam logic [63:0] SAT_VALUE = (64'd1 << ACC_W) - 64'd1;

   token_rec    tokens_due[$];
   token_type   char_tokens[$];
   cfg_type     cfg;
   logic [1:0]  run_cls;
   logic [63:0] digit_acc;
   logic [7:0]  letters [3];
   logic [2:0]  letter_cnt;
   int          errors = 0;
   int          checked = 0;

   function automatic token_type make_tok(logic [1:0] kind, logic [3:0] op,
                                          logic [NUM_W-1:0] num, logic arg);
      token_type t;
      t.kind = kind;
      t.op   = op;
      t.num  = num;
      t.arg  = arg;
      return t;
   endfunction

   // append one predicted token of the current character
   task add_tok(input logic [1:0] kind, input logic [3:0] op,
                input logic [NUM_W-1:0] num, input logic arg);
      char_tokens = {char_tokens, make_tok(kind, op, num, arg)};
   endtask

   // tokens of the open run, then back to no run
   task close_run();
      logic [23:0] word;
      word = {letters[0], letters[1], letters[2]};
      case (run_cls)
         CLS_DIGIT: begin
            add_tok(KIND_NUMBER, OP_NONE, digit_acc[NUM_W-1:0], 1'b0);
         end
         CLS_LETTER: begin
            if (letter_cnt == 3'd1) begin
               if (cfg.first_en && letters[0] == cfg.first_letter)
                  add_tok(KIND_ARG, OP_NONE, '0, 1'b0);
               if (cfg.second_en && letters[0] == cfg.second_letter)
                  add_tok(KIND_ARG, OP_NONE, '0, 1'b1);
            end else if (letter_cnt == 3'd2) begin
               if (word[23:8] == WORD_LN)
                  add_tok(KIND_OPER, OP_LN, '0, 1'b0);
            end else if (letter_cnt == 3'd3) begin
               case (word)
                  WORD_SIN: add_tok(KIND_OPER, OP_SIN, '0, 1'b0);
                  WORD_COS: add_tok(KIND_OPER, OP_COS, '0, 1'b0);
                  WORD_TAN: add_tok(KIND_OPER, OP_TAN, '0, 1'b0);
                  WORD_LOG: add_tok(KIND_OPER, OP_LOG, '0, 1'b0);
                  WORD_EXP: add_tok(KIND_OPER, OP_EXP, '0, 1'b0);
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      run_cls    = CLS_NONE;
      digit_acc  = '0;
      letter_cnt = '0;
   endtask

   task accept_char(input logic [7:0] c, input logic fin);
      logic [1:0]  cls;
      logic [63:0] digit;
      logic [3:0]  op;
      token_rec    r;
      char_tokens.delete();
      if (c >= CH_0 && c <= CH_9)
         cls = CLS_DIGIT;
      else if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ))
         cls = CLS_LETTER;
      else
         cls = CLS_SYMBOL;
      if (cls != run_cls)
         close_run();
      run_cls = cls;
      case (cls)
         CLS_DIGIT: begin
            digit = {56'd0, c - CH_0};
            if (digit_acc > (SAT_VALUE - digit) / 64'd10)
               digit_acc = SAT_VALUE;
            else
               digit_acc = digit_acc * 64'd10 + digit;
         end
         CLS_LETTER: begin
            if (letter_cnt < 3'd3)
               letters[letter_cnt[1:0]] = c;
            if (letter_cnt < 3'd4)
               letter_cnt = letter_cnt + 3'd1;
         end
         default: begin
            case (c)
               CH_PLUS:  op = OP_PLUS;
               CH_MINUS: op = OP_MINUS;
               CH_MUL:   op = OP_MUL;
               CH_DIV:   op = OP_DIV;
               CH_LPAR:  op = OP_LPAR;
               CH_RPAR:  op = OP_RPAR;
               CH_POW:   op = OP_POW;
               default:  op = OP_NONE;
            endcase
            if (op != OP_NONE)
               add_tok(KIND_OPER, op, '0, 1'b0);
         end
      endcase
      if (fin) begin
         close_run();
         add_tok(KIND_END, OP_NONE, '0, 1'b0);
      end
      foreach (char_tokens[i]) begin
         r.tok  = char_tokens[i];
         r.last = (i == char_tokens.size() - 1);
         tokens_due = {tokens_due, r};
      end
   endtask

   always @(posedge clock) begin : watch
      token_rec got;
      token_rec want;
      if (reset) begin
         cfg.first_en      = 1'b1;
         cfg.second_en     = 1'b0;
         cfg.first_letter  = RST_FIRST_LETTER;
         cfg.second_letter = RST_SECOND_LETTER;
         run_cls           = CLS_NONE;
         digit_acc         = '0;
         letter_cnt        = '0;
         foreach (letters[i]) letters[i] = '0;
         tokens_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.tok.kind = rsp_mon.token_kind;
            got.tok.op   = rsp_mon.operator_code;
            got.tok.num  = rsp_mon.number_value;
            got.tok.arg  = rsp_mon.arg_index;
            got.last     = rsp_mon.last_of_run;
            if (tokens_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected token, expected none,", $time);
               $display("%0t:   got kind %0d op %0d value %0d arg %0d last %0d",
                        $time, got.tok.kind, got.tok.op, got.tok.num, got.tok.arg,
                        got.last);
            end else begin
               want = tokens_due.pop_front();
               checked++;
               if (got !== want) begin
                  errors++;
                  $display("%0t: token mismatch, expected kind %0d op %0d value %0d arg %0d last %0d",
                           $time, want.tok.kind, want.tok.op, want.tok.num, want.tok.arg,
                           want.last);
                  $display("%0t:                 got kind %0d op %0d value %0d arg %0d last %0d",
                           $time, got.tok.kind, got.tok.op, got.tok.num, got.tok.arg, got.last);
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_FIRST_EN:      cfg.first_en      = csr_mon.data[0];
               REG_SECOND_EN:     cfg.second_en     = csr_mon.data[0];
               REG_FIRST_LETTER:  cfg.first_letter  = csr_mon.data;
               REG_SECOND_LETTER: cfg.second_letter = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            accept_char(req_mon.char_code, req_mon.is_final);
      end
      error_count   <= errors;
      pending_count <= tokens_due.size();
      token_count   <= checked;
   end

endmodule

// File: test/expression_tokenizer_tb.sv
`timescale 1ns / 1ps
// expression_tokenizer_tb: drives characters and register writes into the tokenizer
// and gives the verdict; depends on exptok_pkg, exptok_if, exptok_checker and the block

module expression_tokenizer_tb;
   import exptok_pkg::*;

   // generous: a few hundred characters, each at most four tokens with stalls
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   exptok_req_if req_if ();
   exptok_rsp_if rsp_if ();
   exptok_csr_if csr_if ();

   int   error_count;
   int   pending_count;
   int   token_count;
   int   chars_sent    = 0;
   int   settings_used = 0;
   int   cycles        = 0;
   int   stall_left    = 0;
   bit   quiet         = 1'b0;  // no idling on either side once set

   expression_tokenizer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   exptok_checker u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_mon       (csr_if),
      .error_count   (error_count),
      .pending_count (pending_count),
      .token_count   (token_count)
   );

   always #5 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d tokens outstanding",
                  cycles, pending_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // token sink: ready drops at random in bursts of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left   <= $urandom_range(0, 3);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // one character request; valid stays high on return so back-to-back requests
   // never lower and raise it in the same step
   task automatic send_char(input logic [7:0] c, input logic fin);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= c;
      req_if.is_final  <= fin;
      do @(posedge clock); while (!req_if.ready);
      chars_sent++;
   endtask

   // whole expression from text, final flag on its last character
   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i], i == s.len() - 1);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // only called with the block idle and no run open
   task automatic apply_config(input logic f_en, input logic s_en,
                               input logic [7:0] f_let, input logic [7:0] s_let);
      write_reg(REG_FIRST_EN, {7'd0, f_en});
      write_reg(REG_SECOND_EN, {7'd0, s_en});
      write_reg(REG_FIRST_LETTER, f_let);
      write_reg(REG_SECOND_LETTER, s_let);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   // drain: every predicted token back, then a wait for requests that give none
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   // random expressions under one register setting, mostly well-formed pieces
   task automatic run_phase(input logic f_en, input logic s_en,
                            input logic [7:0] f_let, input logic [7:0] s_let,
                            input int n_chars);
      logic [7:0]  text[$];
      logic [23:0] fword;
      int          sent;
      int          pick;
      int          len;
      sent = 0;
      apply_config(f_en, s_en, f_let, s_let);
      while (sent < n_chars) begin
         text.delete();
         repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               // number, now and then long enough to saturate
               len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 12)
                                                 : $urandom_range(1, 4);
               repeat (len) text = {text, 8'(CH_0 + $urandom_range(0, 9))};
            end else if (pick < 40) begin
               case ($urandom_range(0, 5))
                  0:       fword = WORD_SIN;
                  1:       fword = WORD_COS;
                  2:       fword = WORD_TAN;
                  3:       fword = WORD_LOG;
                  4:       fword = WORD_EXP;
                  default: fword = {WORD_LN, 8'h00};
               endcase
               text = {text, fword[23:16], fword[15:8]};
               if (fword[7:0] != 8'h00)
                  text = {text, fword[7:0]};
            end else if (pick < 55) begin
               text = {text, ($urandom_range(0, 1) ? f_let : s_let)};
            end else if (pick < 62) begin
               // stray letter run, either case, up to five long
               repeat ($urandom_range(1, 5))
                  text = {text, 8'(($urandom_range(0, 1) ? CH_LA : CH_UA)
                                   + $urandom_range(0, 25))};
            end else if (pick < 90) begin
               case ($urandom_range(0, 6))
                  0:       text = {text, CH_PLUS};
                  1:       text = {text, CH_MINUS};
                  2:       text = {text, CH_MUL};
                  3:       text = {text, CH_DIV};
                  4:       text = {text, CH_LPAR};
                  5:       text = {text, CH_RPAR};
                  default: text = {text, CH_POW};
               endcase
            end else begin
               text = {text, 8'($urandom_range(0, 255))};
            end
         end
         foreach (text[i])
            send_char(text[i], i == text.size() - 1);
         sent += text.size();
      end
      settle();
   endtask

   initial begin
      req_if.valid     <= 1'b0;
      req_if.char_code <= '0;
      req_if.is_final  <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= REG_FIRST_EN;
      csr_if.data      <= '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // both argument letters the same: a lone x closed by an operator on the
      // last character gives the most tokens one request can cause
      apply_config(1'b1, 1'b1, "x", "x");
      send_text("x+");
      // every function name and every operator symbol but plus
      send_text("sin*cos/tan-log(ln)^exp");
      // lone unknown symbol as the whole expression: only the end token
      send_text("#");
      // character code extremes
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      settle();

      run_phase(1'b1, 1'b0, RST_FIRST_LETTER, RST_SECOND_LETTER, 50);
      run_phase(1'b0, 1'b1, "a", "Z", 50);
      run_phase(1'b1, 1'b1, "q", "q", 50);
      run_phase(1'b0, 1'b0, 8'h00, 8'hFF, 50);
      // argument letters that are not letters never match
      run_phase(1'b1, 1'b1, 8'hFF, 8'h00, 50);
      // last stretch at full rate on both sides
      quiet = 1'b1;
      run_phase(1'b1, 1'b1, 8'(CH_LA + $urandom_range(0, 25)),
                8'(CH_UA + $urandom_range(0, 25)), 50);

      $display("%0d characters sent under %0d register settings, %0d tokens checked",
               chars_sent, settings_used, token_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d token errors", error_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
